FILE: rtl/core/btd_pkg.sv
// ----------------------------------------------------------------------------
// btd_pkg: shared types and constants of the task file address builder
// Widths, register indexes, task file bit codes and the pipeline word.
// ----------------------------------------------------------------------------
package btd_pkg;

  // Field widths.
  localparam int WORD_W      = 32;
  localparam int BYTE_W      = 8;
  localparam int HEAD_W      = 5;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 8;

  // Divider bits retired per pipeline stage; must divide WORD_W.
  localparam int STEPS_PER_STAGE = 8;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_LBA_MODE     = 2'd0,
    REG_HEAD_COUNT   = 2'd1,
    REG_SECTORS      = 2'd2,
    REG_SECOND_DRIVE = 2'd3
  } reg_index_t;

  // Drive/head byte codes.
  localparam logic [BYTE_W-1:0] FLAG_LBA   = 8'h40;
  localparam logic [BYTE_W-1:0] SEL_FIRST  = 8'hA0;
  localparam logic [BYTE_W-1:0] SEL_SECOND = 8'hB0;

  // Geometry after reset.
  localparam logic [HEAD_W-1:0] RESET_HEADS   = 5'd16;
  localparam logic [BYTE_W-1:0] RESET_SECTORS = 8'd63;

  // Configuration as seen by the pipeline.
  typedef struct packed {
    logic              lba_mode;
    logic [HEAD_W-1:0] head_count;
    logic [BYTE_W-1:0] sectors_per_track;
    logic              second_drive;
  } cfg_t;

  // Fields that ride along with the divider.
  typedef struct packed {
    logic [WORD_W-1:0] block_number;
    logic [BYTE_W-1:0] transfer_sectors;
    logic [BYTE_W-1:0] sector_rem;
  } side_t;

  // One pipeline word: dividend shifting into quotient, partial remainder.
  typedef struct packed {
    logic [WORD_W-1:0] work;
    logic [BYTE_W-1:0] rem;
    side_t             side;
  } div_word_t;

endpackage

FILE: rtl/core/btd_if.sv
// ----------------------------------------------------------------------------
// btd_cmd_if / btd_tf_if: command and task file channels
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface btd_cmd_if import btd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] block_number;
  logic [BYTE_W-1:0] transfer_sectors;

  modport source (output valid, block_number, transfer_sectors, input ready);
  modport sink   (input valid, block_number, transfer_sectors, output ready);
endinterface

interface btd_tf_if import btd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] count_byte;
  logic [BYTE_W-1:0] sector_byte;
  logic [BYTE_W-1:0] cylinder_low_byte;
  logic [BYTE_W-1:0] cylinder_high_byte;
  logic [BYTE_W-1:0] drive_head_byte;
  logic              address_overflow;

  modport source (output valid, count_byte, sector_byte, cylinder_low_byte,
                  cylinder_high_byte, drive_head_byte, address_overflow,
                  input ready);
  modport sink   (input valid, count_byte, sector_byte, cylinder_low_byte,
                  cylinder_high_byte, drive_head_byte, address_overflow,
                  output ready);
endinterface

FILE: rtl/core/block_to_disk_taskfile_address.sv
// ----------------------------------------------------------------------------
// block_to_disk_taskfile_address: block number to disk task file bytes
// LBA slicing or CHS translation through a pipelined restoring divider.
// ----------------------------------------------------------------------------
// Channel  | Role   | Word
// ---------+--------+------------------------------------------------------
// cmd      | sink   | block_number, transfer_sectors
// tf       | source | count, sector, cylinder low/high, drive/head, overflow
// cfg_*    | write  | lba_mode, head_count, sectors_per_track, second_drive
//
// One word per cycle while tf accepts words; each of the two chained 32-bit divisions
// (by sectors, then by heads) retires STEPS quotient bits per register stage,
// and the output register follows the second division.
// Reset clears the valid bits and loads the default geometry (16 heads, 63
// sectors, CHS, first drive). A stalled output fills bubbles upstream first;
// cmd.ready drops only when every stage holds a word.
// ----------------------------------------------------------------------------
module block_to_disk_taskfile_address import btd_pkg::*; #(
  parameter int STEPS = STEPS_PER_STAGE
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wen,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  btd_cmd_if.sink                cmd,
  btd_tf_if.source               tf
);

  localparam int DIV_STAGES = WORD_W / STEPS;
  localparam int TOTAL      = 2 * DIV_STAGES;

  cfg_t      cfg;
  logic      chain_valid [0:TOTAL];
  logic      chain_ready [0:TOTAL];
  div_word_t chain_data  [0:TOTAL];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lba_mode          <= 1'b0;
      cfg.head_count        <= RESET_HEADS;
      cfg.sectors_per_track <= RESET_SECTORS;
      cfg.second_drive      <= 1'b0;
    end else if (cfg_wen) begin
      unique case (reg_index_t'(cfg_index))
        REG_LBA_MODE:     cfg.lba_mode          <= cfg_data[0];
        REG_HEAD_COUNT:   cfg.head_count        <= cfg_data[HEAD_W-1:0];
        REG_SECTORS:      cfg.sectors_per_track <= cfg_data;
        REG_SECOND_DRIVE: cfg.second_drive      <= cfg_data[0];
      endcase
    end
  end

  // Command word enters the first divider with a cleared remainder.
  assign chain_valid[0]                  = cmd.valid;
  assign cmd.ready                       = chain_ready[0];
  assign chain_data[0].work              = cmd.block_number;
  assign chain_data[0].rem               = '0;
  assign chain_data[0].side.block_number = cmd.block_number;
  assign chain_data[0].side.transfer_sectors = cmd.transfer_sectors;
  assign chain_data[0].side.sector_rem   = '0;

  // Divider chain: block / sectors, then that quotient / heads.
  for (genvar k = 0; k < TOTAL; k++) begin : g_stage
    div_word_t         stage_in;
    logic [BYTE_W-1:0] stage_divisor;

    if (k == DIV_STAGES) begin : g_handoff
      // The sector remainder is parked and the quotient becomes the dividend.
      assign stage_in.work            = chain_data[k].work;
      assign stage_in.rem             = '0;
      assign stage_in.side.block_number     = chain_data[k].side.block_number;
      assign stage_in.side.transfer_sectors = chain_data[k].side.transfer_sectors;
      assign stage_in.side.sector_rem = chain_data[k].rem;
    end else begin : g_pass
      assign stage_in = chain_data[k];
    end

    if (k < DIV_STAGES) begin : g_by_sectors
      assign stage_divisor = cfg.sectors_per_track;
    end else begin : g_by_heads
      assign stage_divisor = BYTE_W'(cfg.head_count);
    end

    btd_div_stage #(
      .STEPS (STEPS)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (chain_valid[k]),
      .in_ready  (chain_ready[k]),
      .in_data   (stage_in),
      .divisor   (stage_divisor),
      .out_valid (chain_valid[k+1]),
      .out_ready (chain_ready[k+1]),
      .out_data  (chain_data[k+1])
    );
  end

  // Byte assembly and output register.
  btd_format u_format (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (chain_valid[TOTAL]),
    .in_ready (chain_ready[TOTAL]),
    .in_data  (chain_data[TOTAL]),
    .tf       (tf)
  );

`ifndef SYNTHESIS
  // The drive select bits always survive in the drive/head byte.
  a_select_bits: assert property (@(posedge clk) disable iff (rst)
    tf.valid |-> (tf.drive_head_byte[7] && tf.drive_head_byte[5]))
    else $error("drive select bits lost in drive/head byte");

  // A CHS result that fits has a one-based sector number.
  a_chs_sector: assert property (@(posedge clk) disable iff (rst)
    (tf.valid && !tf.address_overflow && !tf.drive_head_byte[6])
      |-> (tf.sector_byte != 8'd0))
    else $error("CHS sector number is zero without overflow");

  // Back pressure reaches the command side only when the pipeline is full.
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !cmd.ready |-> (chain_valid[1] && tf.valid && !tf.ready))
    else $error("command stalled while the pipeline has room");
`endif

endmodule

FILE: rtl/core/btd_div_stage.sv
// ----------------------------------------------------------------------------
// btd_div_stage: one register stage of the restoring divider
// Retires STEPS quotient bits of a 32-bit dividend by an 8-bit divisor.
// ----------------------------------------------------------------------------
module btd_div_stage import btd_pkg::*; #(
  parameter int STEPS = STEPS_PER_STAGE
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  div_word_t         in_data,
  input  logic [BYTE_W-1:0] divisor,
  output logic              out_valid,
  input  logic              out_ready,
  output div_word_t         out_data
);

  logic      valid;
  div_word_t data;
  div_word_t data_next;

  // The stage takes a word when it is empty or its word moves on.
  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  // Shift one dividend bit into the remainder per step and subtract if it fits.
  always_comb begin
    div_word_t         acc;
    logic [BYTE_W:0]   trial;
    acc = in_data;
    for (int i = 0; i < STEPS; i++) begin
      trial    = {acc.rem, acc.work[WORD_W-1]};
      acc.work = {acc.work[WORD_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        acc.rem     = BYTE_W'(trial - {1'b0, divisor});
        acc.work[0] = 1'b1;
      end else begin
        acc.rem = trial[BYTE_W-1:0];
      end
    end
    data_next = acc;
  end

  // Valid bit under reset; payload loads with the handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      data <= data_next;
    end
  end

endmodule

FILE: rtl/core/btd_format.sv
// ----------------------------------------------------------------------------
// btd_format: task file byte assembly and output register
// Builds the five task file bytes and overflow flag from the divider word.
// ----------------------------------------------------------------------------
module btd_format import btd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       in_valid,
  output logic       in_ready,
  input  div_word_t  in_data,
  btd_tf_if.source   tf
);

  logic              valid;
  logic [BYTE_W-1:0] count_byte;
  logic [BYTE_W-1:0] sector_byte;
  logic [BYTE_W-1:0] cylinder_low_byte;
  logic [BYTE_W-1:0] cylinder_high_byte;
  logic [BYTE_W-1:0] drive_head_byte;
  logic              address_overflow;

  logic [BYTE_W-1:0] sector_next;
  logic [15:0]       cylinder_next;
  logic [BYTE_W-1:0] drive_head_next;
  logic              overflow_next;
  logic [BYTE_W-1:0] select;
  logic [WORD_W-1:0] blk;

  assign in_ready = !valid || tf.ready;

  assign tf.valid              = valid;
  assign tf.count_byte         = count_byte;
  assign tf.sector_byte        = sector_byte;
  assign tf.cylinder_low_byte  = cylinder_low_byte;
  assign tf.cylinder_high_byte = cylinder_high_byte;
  assign tf.drive_head_byte    = drive_head_byte;
  assign tf.address_overflow   = address_overflow;

  assign select = cfg.second_drive ? SEL_SECOND : SEL_FIRST;
  assign blk    = in_data.side.block_number;

  // LBA slices, zero geometry, or CHS translation from the division results.
  always_comb begin
    priority if (cfg.lba_mode) begin
      sector_next     = blk[7:0];
      cylinder_next   = blk[23:8];
      drive_head_next = {4'b0000, blk[27:24]} | FLAG_LBA | select;
      overflow_next   = |blk[31:28];
    end else if (cfg.head_count == '0 || cfg.sectors_per_track == '0) begin
      sector_next     = '0;
      cylinder_next   = '0;
      drive_head_next = select;
      overflow_next   = 1'b1;
    end else begin
      sector_next     = in_data.side.sector_rem + 8'd1;
      cylinder_next   = in_data.work[15:0];
      drive_head_next = {4'b0000, in_data.rem[3:0]} | select;
      overflow_next   = (|in_data.work[WORD_W-1:16]) || (|in_data.rem[BYTE_W-1:4]);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      count_byte         <= in_data.side.transfer_sectors;
      sector_byte        <= sector_next;
      cylinder_low_byte  <= cylinder_next[7:0];
      cylinder_high_byte <= cylinder_next[15:8];
      drive_head_byte    <= drive_head_next;
      address_overflow   <= overflow_next;
    end
  end

endmodule
